// ----- src/bmpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types and constants for the pipelined temperature and pressure
// compensation datapath.
// ----------------------------------------------------------------------------
package bmpc_pkg;

    localparam int DIV_W = 64;

    localparam logic signed [32:0] T_OFFSET = 33'sd128000;
    localparam logic [20:0]        RAW_FULL = 21'd1048576;
    localparam logic signed [63:0] P_SCALE  = 64'sd3125;
    localparam logic signed [63:0] P_BIAS   = 64'sh0000_8000_0000_0000;
    localparam logic signed [31:0] T_ROUND  = 32'sd128;

    typedef enum logic [2:0] {
        REG_T1    = 3'd0,
        REG_T2    = 3'd1,
        REG_T3    = 3'd2,
        REG_P1    = 3'd3,
        REG_P2_P3 = 3'd4,
        REG_P4_P5 = 3'd5,
        REG_P6_P7 = 3'd6,
        REG_P8_P9 = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
    } tcal_t;

    typedef struct packed {
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } pcal_t;

    // Per-item data that rides along with the pressure math.
    typedef struct packed {
        logic signed [31:0] fine;
        logic signed [23:0] tc;
        logic               nz;
    } side_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] mb;
        logic             neg;
        side_t            side;
    } div_t;

endpackage

// ----- src/bmpc_temp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature stages
// Three register stages that produce the fine temperature with 32-bit
// wrapping arithmetic.
// ----------------------------------------------------------------------------
module bmpc_temp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [19:0]           rt,
    input  logic [19:0]           rp,
    input  bmpc_pkg::tcal_t       tcal,
    output logic                  valid,
    output logic signed [31:0]    fine,
    output logic [19:0]           rp_o
);

    logic               s1_v_reg, s2_v_reg, s3_v_reg;
    logic [31:0]        s1_pa_reg, s1_dd_reg;
    logic [19:0]        s1_rp_reg, s2_rp_reg, s3_rp_reg;
    logic signed [31:0] s2_a_reg, s2_e_reg, s3_fine_reg;

    logic [31:0]        dif_a, dif_d, pa_next, dd_next;
    logic signed [31:0] dd_sh, a_next, e_next, fine_next;

    always_comb
    begin
        dif_a     = 32'(rt >> 3) - {15'b0, tcal.t1, 1'b0};
        dif_d     = 32'(rt >> 4) - {16'b0, tcal.t1};
        pa_next   = dif_a * 32'(tcal.t2);
        dd_next   = dif_d * dif_d;
        a_next    = $signed(s1_pa_reg) >>> 11;
        dd_sh     = $signed(s1_dd_reg) >>> 12;
        e_next    = dd_sh * 32'(tcal.t3);
        fine_next = s2_a_reg + (s2_e_reg >>> 14);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pa_reg   <= pa_next;
            s1_dd_reg   <= dd_next;
            s1_rp_reg   <= rp;
            s2_a_reg    <= a_next;
            s2_e_reg    <= e_next;
            s2_rp_reg   <= s1_rp_reg;
            s3_fine_reg <= fine_next;
            s3_rp_reg   <= s2_rp_reg;
        end
    end

    assign valid = s3_v_reg;
    assign fine  = s3_fine_reg;
    assign rp_o  = s3_rp_reg;

endmodule

// ----- src/bmpc_pcoef.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure coefficient stages
// Five register stages that build the 64-bit dividend and divisor from the
// fine temperature and the raw pressure.
// ----------------------------------------------------------------------------
module bmpc_pcoef (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [31:0]    fine,
    input  logic [19:0]           rp,
    input  bmpc_pkg::pcal_t       pcal,
    output logic                  valid,
    output logic signed [63:0]    num,
    output logic signed [63:0]    den,
    output bmpc_pkg::side_t       side
);

    logic               s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg, s8_v_reg;
    bmpc_pkg::side_t    s4_sd_reg, s5_sd_reg, s6_sd_reg, s7_sd_reg, s8_sd_reg;
    logic [19:0]        s4_rp_reg, s5_rp_reg, s6_rp_reg;
    logic signed [63:0] s4_vv_reg;
    logic signed [48:0] s4_m5_reg, s4_m2_reg, s5_m5_reg, s5_m2_reg;
    logic signed [63:0] s5_t6_reg, s5_t3_reg;
    logic signed [63:0] s6_v2_reg, s6_v1_reg;
    logic signed [63:0] s7_q_reg, s7_n_reg;
    logic signed [63:0] s8_num_reg, s8_den_reg;

    logic signed [32:0] v1;
    logic signed [65:0] vv_full;
    logic signed [48:0] m5_next, m2_next;
    logic signed [31:0] t5;
    bmpc_pkg::side_t    sd_next, sd8_next;
    logic signed [63:0] t6_next, t3_next, v2_next, v1_next, q_next, n_next;
    logic signed [63:0] den_next, num_next;

    always_comb
    begin
        v1       = 33'(fine) - bmpc_pkg::T_OFFSET;
        vv_full  = v1 * v1;
        m5_next  = 49'(v1) * 49'(pcal.p5);
        m2_next  = 49'(v1) * 49'(pcal.p2);
        t5       = (fine <<< 2) + fine + bmpc_pkg::T_ROUND;
        sd_next.fine = fine;
        sd_next.tc   = 24'(t5 >>> 8);
        sd_next.nz   = 1'b0;

        t6_next  = s4_vv_reg * 64'(pcal.p6);
        t3_next  = s4_vv_reg * 64'(pcal.p3);

        v2_next  = s5_t6_reg + (64'(s5_m5_reg) <<< 17) + (64'(pcal.p4) <<< 35);
        v1_next  = (s5_t3_reg >>> 8) + (64'(s5_m2_reg) <<< 12);

        q_next   = (bmpc_pkg::P_BIAS + s6_v1_reg) * $signed({48'b0, pcal.p1});
        n_next   = $signed(64'(bmpc_pkg::RAW_FULL - {1'b0, s6_rp_reg}) << 31) - s6_v2_reg;

        den_next = s7_q_reg >>> 33;
        num_next = s7_n_reg * bmpc_pkg::P_SCALE;
        sd8_next    = s7_sd_reg;
        sd8_next.nz = |den_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
            s8_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= in_valid;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
            s8_v_reg <= s7_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_sd_reg  <= sd_next;
            s4_rp_reg  <= rp;
            s4_vv_reg  <= vv_full[63:0];
            s4_m5_reg  <= m5_next;
            s4_m2_reg  <= m2_next;
            s5_sd_reg  <= s4_sd_reg;
            s5_rp_reg  <= s4_rp_reg;
            s5_t6_reg  <= t6_next;
            s5_t3_reg  <= t3_next;
            s5_m5_reg  <= s4_m5_reg;
            s5_m2_reg  <= s4_m2_reg;
            s6_sd_reg  <= s5_sd_reg;
            s6_rp_reg  <= s5_rp_reg;
            s6_v2_reg  <= v2_next;
            s6_v1_reg  <= v1_next;
            s7_sd_reg  <= s6_sd_reg;
            s7_q_reg   <= q_next;
            s7_n_reg   <= n_next;
            s8_sd_reg  <= sd8_next;
            s8_den_reg <= den_next;
            s8_num_reg <= num_next;
        end
    end

    assign valid = s8_v_reg;
    assign num   = s8_num_reg;
    assign den   = s8_den_reg;
    assign side  = s8_sd_reg;

endmodule

// ----- src/bmpc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division of magnitudes, one quotient bit per stage, with a
// sign stage before and after. The quotient truncates toward zero.
// ----------------------------------------------------------------------------
module bmpc_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [63:0]    num,
    input  logic signed [63:0]    den,
    input  bmpc_pkg::side_t       side_i,
    output logic                  valid,
    output logic signed [63:0]    quo,
    output bmpc_pkg::side_t       side_o
);

    localparam int W = bmpc_pkg::DIV_W;

    bmpc_pkg::div_t  stage_reg [W+1];
    logic            v_reg     [W+1];
    bmpc_pkg::div_t  prep_next;
    logic            fin_v_reg;
    logic [W-1:0]    fin_q_reg;
    bmpc_pkg::side_t fin_sd_reg;
    logic [W-1:0]    q_next;

    always_comb
    begin
        prep_next.rem  = '0;
        prep_next.quot = num[W-1] ? (W'(0) - W'(num)) : W'(num);
        prep_next.mb   = den[W-1] ? (W'(0) - W'(den)) : W'(den);
        prep_next.neg  = num[W-1] ^ den[W-1];
        prep_next.side = side_i;
        q_next = stage_reg[W].neg ? (W'(0) - stage_reg[W].quot) : stage_reg[W].quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stage_reg[0] <= prep_next;
    end

    for (genvar i = 0; i < W; i++)
    begin : g_step
        bmpc_pkg::div_t step_next;
        logic [W:0]     trial;

        always_comb
        begin
            step_next      = stage_reg[i];
            trial          = {stage_reg[i].rem, stage_reg[i].quot[W-1]};
            step_next.quot = {stage_reg[i].quot[W-2:0], 1'b0};
            if (trial >= {1'b0, stage_reg[i].mb})
            begin
                step_next.rem     = W'(trial - {1'b0, stage_reg[i].mb});
                step_next.quot[0] = 1'b1;
            end
            else
            begin
                step_next.rem = trial[W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                stage_reg[i+1] <= step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_v_reg <= 1'b0;
        else if (en)
            fin_v_reg <= v_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_q_reg  <= q_next;
            fin_sd_reg <= stage_reg[W].side;
        end
    end

    assign valid  = fin_v_reg;
    assign quo    = $signed(fin_q_reg);
    assign side_o = fin_sd_reg;

endmodule

// ----- src/bmpc_pfin.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure finishing stages
// Four register stages that apply the second-order pressure correction and
// hold the result beat.
// ----------------------------------------------------------------------------
module bmpc_pfin (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [63:0]    p,
    input  bmpc_pkg::side_t       side,
    input  bmpc_pkg::pcal_t       pcal,
    output logic                  valid,
    output logic signed [31:0]    fine,
    output logic signed [23:0]    tc,
    output logic [31:0]           pres,
    output logic                  pres_ok
);

    logic               f1_v_reg, f2_v_reg, f3_v_reg, f4_v_reg;
    bmpc_pkg::side_t    f1_sd_reg, f2_sd_reg, f3_sd_reg, f4_sd_reg;
    logic signed [63:0] f1_p_reg, f2_p_reg, f3_p_reg;
    logic [63:0]        f1_ll_reg;
    logic [31:0]        f1_lh_reg;
    logic signed [63:0] f1_m8_reg, f2_xx_reg, f2_v2_reg, f3_v2_reg, f3_m9_reg;
    logic [31:0]        f4_pres_reg;

    logic signed [63:0] x, m8_next, xx_next, v2_next, m9_next, v1p, r;
    logic [31:0]        xl, lh_next;
    logic [63:0]        ll_next;

    always_comb
    begin
        x       = p >>> 13;
        xl      = x[31:0];
        ll_next = 64'(xl) * 64'(xl);
        lh_next = xl * 32'($signed(x[50:32]));
        m8_next = p * 64'(pcal.p8);

        // Low word of the square: the cross term lands in the upper half.
        xx_next = $signed(f1_ll_reg + {f1_lh_reg[30:0], 33'b0});
        v2_next = f1_m8_reg >>> 19;

        m9_next = f2_xx_reg * 64'(pcal.p9);

        v1p = f3_m9_reg >>> 25;
        r   = ((f3_p_reg + v1p + f3_v2_reg) >>> 8) + (64'(pcal.p7) <<< 4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
            f4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= in_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
            f4_v_reg <= f3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_sd_reg   <= side;
            f1_p_reg    <= p;
            f1_ll_reg   <= ll_next;
            f1_lh_reg   <= lh_next;
            f1_m8_reg   <= m8_next;
            f2_sd_reg   <= f1_sd_reg;
            f2_p_reg    <= f1_p_reg;
            f2_xx_reg   <= xx_next;
            f2_v2_reg   <= v2_next;
            f3_sd_reg   <= f2_sd_reg;
            f3_p_reg    <= f2_p_reg;
            f3_v2_reg   <= f2_v2_reg;
            f3_m9_reg   <= m9_next;
            f4_sd_reg   <= f3_sd_reg;
            f4_pres_reg <= f3_sd_reg.nz ? r[31:0] : 32'd0;
        end
    end

    assign valid   = f4_v_reg;
    assign fine    = f4_sd_reg.fine;
    assign tc      = f4_sd_reg.tc;
    assign pres    = f4_pres_reg;
    assign pres_ok = f4_sd_reg.nz;

endmodule

// ----- src/baro_temp_pressure_compensation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric temperature and pressure compensation
// Integer compensation of raw 20-bit temperature and pressure readings with
// twelve calibration words, fully pipelined.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    raw_temperature, raw_pressure
//   result    out_valid / out_ready  fine_temperature, temperature_centi,
//                                    pressure_q24_8, pressure_valid
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat is accepted per cycle while the result is not stalled; each result
// passes through the 66-stage divider plus twelve arithmetic stages.
// Reset clears all valid bits and the calibration registers to zero.
// A stalled result freezes the whole pipeline; in_ready drops only then.
// Configuration writes are always ready and take effect in the cycle after the write.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [19:0]        raw_temperature,
    input  logic [19:0]        raw_pressure,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] fine_temperature,
    output logic signed [23:0] temperature_centi,
    output logic [31:0]        pressure_q24_8,
    output logic               pressure_valid,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [15:0] t1_reg, t2_reg, t3_reg, p1_reg;
    logic [31:0] p23_reg, p45_reg, p67_reg, p89_reg;

    bmpc_pkg::tcal_t tcal;
    bmpc_pkg::pcal_t pcal;

    logic               en;
    logic               tv, pv, dv;
    logic signed [31:0] t_fine;
    logic [19:0]        t_rp;
    logic signed [63:0] num, den, quo;
    bmpc_pkg::side_t    p_side, d_side;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg  <= '0;
            t2_reg  <= '0;
            t3_reg  <= '0;
            p1_reg  <= '0;
            p23_reg <= '0;
            p45_reg <= '0;
            p67_reg <= '0;
            p89_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (bmpc_pkg::cfg_idx_t'(cfg_index))
                bmpc_pkg::REG_T1:    t1_reg  <= cfg_data[15:0];
                bmpc_pkg::REG_T2:    t2_reg  <= cfg_data[15:0];
                bmpc_pkg::REG_T3:    t3_reg  <= cfg_data[15:0];
                bmpc_pkg::REG_P1:    p1_reg  <= cfg_data[15:0];
                bmpc_pkg::REG_P2_P3: p23_reg <= cfg_data;
                bmpc_pkg::REG_P4_P5: p45_reg <= cfg_data;
                bmpc_pkg::REG_P6_P7: p67_reg <= cfg_data;
                bmpc_pkg::REG_P8_P9: p89_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        tcal.t1 = t1_reg;
        tcal.t2 = $signed(t2_reg);
        tcal.t3 = $signed(t3_reg);
        pcal.p1 = p1_reg;
        pcal.p2 = $signed(p23_reg[15:0]);
        pcal.p3 = $signed(p23_reg[31:16]);
        pcal.p4 = $signed(p45_reg[15:0]);
        pcal.p5 = $signed(p45_reg[31:16]);
        pcal.p6 = $signed(p67_reg[15:0]);
        pcal.p7 = $signed(p67_reg[31:16]);
        pcal.p8 = $signed(p89_reg[15:0]);
        pcal.p9 = $signed(p89_reg[31:16]);
    end

    // The result register is the last pipeline stage.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    bmpc_temp u_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .rt       (raw_temperature),
        .rp       (raw_pressure),
        .tcal     (tcal),
        .valid    (tv),
        .fine     (t_fine),
        .rp_o     (t_rp)
    );

    bmpc_pcoef u_pcoef (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (tv),
        .fine     (t_fine),
        .rp       (t_rp),
        .pcal     (pcal),
        .valid    (pv),
        .num      (num),
        .den      (den),
        .side     (p_side)
    );

    bmpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (pv),
        .num      (num),
        .den      (den),
        .side_i   (p_side),
        .valid    (dv),
        .quo      (quo),
        .side_o   (d_side)
    );

    bmpc_pfin u_pfin (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (dv),
        .p        (quo),
        .side     (d_side),
        .pcal     (pcal),
        .valid    (out_valid),
        .fine     (fine_temperature),
        .tc       (temperature_centi),
        .pres     (pressure_q24_8),
        .pres_ok  (pressure_valid)
    );

    a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pressure_valid |-> pressure_q24_8 == 32'd0)
        else $error("pressure not forced to zero on zero divisor");

    a_tc_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> temperature_centi ==
            24'(((fine_temperature <<< 2) + fine_temperature + bmpc_pkg::T_ROUND) >>> 8))
        else $error("centi temperature does not match fine temperature");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipeline is stalled");

endmodule

// ----- dv/bmpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric compensation checker
// Watches the calibration, sample and result channels of the compensation
// block, computes the expected fine temperature, centi-degree temperature and
// Q24.8 pressure for every accepted sample beat and compares result beats.
// ----------------------------------------------------------------------------
module bmpc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [19:0]        raw_temperature,
    input  logic [19:0]        raw_pressure,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] fine_temperature,
    input  logic signed [23:0] temperature_centi,
    input  logic [31:0]        pressure_q24_8,
    input  logic               pressure_valid,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count,
    output int                 invalid_count
);

    typedef struct packed {
        logic signed [31:0] fine;
        logic signed [23:0] centi;
        logic [31:0]        pres;
        logic               ok;
    } comp_t;

    logic [31:0] cal [8];
    comp_t       expected_q [$];

    function automatic logic signed [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic comp_t compensate(input logic [19:0] rt, input logic [19:0] rp);
        logic signed [31:0] t1, t2, t3, a, b, d, fine, tc;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] v1, v2, p, na, nb, q;
        comp_t r;
        t1 = {16'd0, cal[bmpc_pkg::REG_T1][15:0]};
        t2 = {{16{cal[bmpc_pkg::REG_T2][15]}}, cal[bmpc_pkg::REG_T2][15:0]};
        t3 = {{16{cal[bmpc_pkg::REG_T3][15]}}, cal[bmpc_pkg::REG_T3][15:0]};
        p1 = {48'd0, cal[bmpc_pkg::REG_P1][15:0]};
        p2 = sext16(cal[bmpc_pkg::REG_P2_P3][15:0]);
        p3 = sext16(cal[bmpc_pkg::REG_P2_P3][31:16]);
        p4 = sext16(cal[bmpc_pkg::REG_P4_P5][15:0]);
        p5 = sext16(cal[bmpc_pkg::REG_P4_P5][31:16]);
        p6 = sext16(cal[bmpc_pkg::REG_P6_P7][15:0]);
        p7 = sext16(cal[bmpc_pkg::REG_P6_P7][31:16]);
        p8 = sext16(cal[bmpc_pkg::REG_P8_P9][15:0]);
        p9 = sext16(cal[bmpc_pkg::REG_P8_P9][31:16]);
        a = (({12'd0, rt} >> 3) - (t1 << 1)) * t2;
        a = a >>> 11;
        d = ({12'd0, rt} >> 4) - t1;
        b = d * d;
        b = b >>> 12;
        b = b * t3;
        b = b >>> 14;
        fine = a + b;
        tc = fine * 32'sd5 + 32'sd128;
        tc = tc >>> 8;
        r.fine = fine;
        r.centi = tc[23:0];
        r.pres = '0;
        r.ok = 1'b0;
        v1 = 64'(fine) - 64'sd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        if (v1 != 0) begin
            p = 64'sd1048576 - 64'(rp);
            p = ((p <<< 31) - v2) * 64'sd3125;
            // Divide on magnitudes so the quotient truncates toward zero.
            na = p[63] ? -p : p;
            nb = v1[63] ? -v1 : v1;
            q = $signed($unsigned(na) / $unsigned(nb));
            p = (p[63] != v1[63]) ? -q : q;
            v1 = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
            v2 = (p8 * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            r.pres = p[31:0];
            r.ok = 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        comp_t e;
        int    errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                cal[i] <= '0;
            expected_q.delete();
            fail_count    <= 0;
            result_count  <= 0;
            invalid_count <= 0;
        end
        else
        begin
            // Predict with the calibration in force before this edge's write.
            if (in_valid && in_ready)
                expected_q.push_back(compensate(raw_temperature, raw_pressure));
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (!pressure_valid)
                    invalid_count <= invalid_count + 1;
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no sample outstanding");
                    errs++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (fine_temperature !== e.fine)
                    begin
                        $error("fine_temperature expected %0d got %0d", e.fine,
                               fine_temperature);
                        errs++;
                    end
                    if (temperature_centi !== e.centi)
                    begin
                        $error("temperature_centi expected %0d got %0d", e.centi,
                               temperature_centi);
                        errs++;
                    end
                    if (pressure_q24_8 !== e.pres)
                    begin
                        $error("pressure_q24_8 expected %h got %h", e.pres,
                               pressure_q24_8);
                        errs++;
                    end
                    if (pressure_valid !== e.ok)
                    begin
                        $error("pressure_valid expected %b got %b", e.ok,
                               pressure_valid);
                        errs++;
                    end
                end
                fail_count <= fail_count + errs;
            end
            if (cfg_valid && cfg_ready)
                cal[cfg_index] <= cfg_index < bmpc_pkg::REG_P2_P3 ?
                                  {16'd0, cfg_data[15:0]} : cfg_data;
        end
    end

    assign pending = expected_q.size();

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Drives calibration sets and raw sample pairs into the compensation block
// under random source and sink stalls; a checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

    localparam int LATENCY = 78;
    localparam int LIMIT   = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [19:0]        raw_temperature = '0;
    logic [19:0]        raw_pressure = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] fine_temperature;
    logic signed [23:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    int                 fail_count, pending, result_count, invalid_count;
    int                 src_idle = 0, sink_idle = 0;
    int                 cycle = 0;
    int                 sample_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    baro_temp_pressure_compensation i_dut (.*);

    bmpc_checker i_checker (.*);

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("Some tests failed");
            $finish;
        end
    end

    // The sink stalls at random; one assignment per falling edge.
    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= sink_idle);

    // Valid stays high between back-to-back writes; the next sample drops it.
    task automatic write_cal(input bmpc_pkg::cfg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Valid stays high into the next beat unless the source idles or drains.
    task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        raw_temperature <= rt;
        raw_pressure    <= rp;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sample_count++;
    endtask

    task automatic wait_empty();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic drain();
        wait_empty();
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Typical datasheet-like calibration, slightly randomized.
    task automatic load_typical();
        write_cal(bmpc_pkg::REG_T1, 16'd27504 + $urandom_range(255));
        write_cal(bmpc_pkg::REG_T2, 16'd26435);
        write_cal(bmpc_pkg::REG_T3, 16'hFC18);
        write_cal(bmpc_pkg::REG_P1, 16'd36477 + $urandom_range(255));
        write_cal(bmpc_pkg::REG_P2_P3, {16'd3024, 16'hD5D4});
        write_cal(bmpc_pkg::REG_P4_P5, {16'hFF73, 16'd2855});
        write_cal(bmpc_pkg::REG_P6_P7, {16'd15500, 16'hFFF9});
        write_cal(bmpc_pkg::REG_P8_P9, {16'd6000, 16'hC0B8});
    endtask

    task automatic load_random();
        bmpc_pkg::cfg_idx_t idx;
        for (int i = 0; i < 8; i++)
        begin
            idx = bmpc_pkg::cfg_idx_t'(i);
            write_cal(idx, $urandom());
        end
    endtask

    task automatic load_all(input logic [31:0] value);
        bmpc_pkg::cfg_idx_t idx;
        for (int i = 0; i < 8; i++)
        begin
            idx = bmpc_pkg::cfg_idx_t'(i);
            write_cal(idx, value);
        end
    endtask

    task automatic realistic_run(input int n);
        for (int i = 0; i < n; i++)
            send_sample(20'd400000 + $urandom_range(300000),
                        20'd250000 + $urandom_range(300000));
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset calibration: pressure divisor is zero.
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        drain();

        load_typical();
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        send_sample(20'd0, 20'hFFFFF);
        send_sample(20'hFFFFF, 20'd0);
        send_sample(20'h55555, 20'hAAAAA);
        send_sample(20'hAAAAA, 20'h55555);
        send_sample(20'd519888, 20'd415148);
        drain();

        load_all(32'hFFFFFFFF);
        send_sample(20'hFFFFF, 20'd0);
        send_sample(20'd0, 20'hFFFFF);
        drain();
        load_all(32'h80008000);
        send_sample(20'd0, 20'd0);
        send_sample(20'hFFFFF, 20'hFFFFF);
        drain();
        load_all(32'h7FFF7FFF);
        send_sample(20'd12345, 20'd678);
        send_sample(20'hFFFFF, 20'd0);
        drain();
        // Zero p1 forces a zero divisor under otherwise typical values.
        load_typical();
        write_cal(bmpc_pkg::REG_P1, 16'd0);
        send_sample(20'd500000, 20'd300000);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle  = phase == 0 ? 26 : (phase == 1 ? 61 : 0);
            sink_idle = phase == 0 ? 61 : (phase == 1 ? 26 : 0);
            load_typical();
            realistic_run(140);
            // Hold the source until every result is back, then continue.
            wait_empty();
            realistic_run(60);
            drain();
            load_random();
            for (int i = 0; i < 45; i++)
                send_sample($urandom(), $urandom());
            drain();
        end

        $display("%0d samples, %0d results, %0d with a zero pressure divisor",
                 sample_count, result_count, invalid_count);
        $display("calibration: reset, typical, all-ones, minimum, maximum, random");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
